>>> hdl/motor_command_frame_parser_defines.svh
// Assertion macros used by the checker file.
`ifndef MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCFP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCFP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mcfp_pkg.sv
package mcfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ID_W    = 2;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned STORE_DEPTH = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame byte positions
  localparam logic [POS_W-1:0] POS_CMD    = 3'd0;
  localparam logic [POS_W-1:0] POS_STATUS = 3'd1;
  localparam logic [POS_W-1:0] POS_ID     = 3'd2;
  localparam logic [POS_W-1:0] POS_DATA_L = 3'd3;
  localparam logic [POS_W-1:0] POS_DATA_H = 3'd4;

  // Reply byte indexes
  localparam logic [POS_W-1:0] RPL_CMD    = 3'd0;
  localparam logic [POS_W-1:0] RPL_STATUS = 3'd1;
  localparam logic [POS_W-1:0] RPL_ID     = 3'd2;
  localparam logic [POS_W-1:0] RPL_WORD_L = 3'd3;
  localparam logic [POS_W-1:0] RPL_WORD_H = 3'd4;

  localparam logic [BYTE_W-1:0] MAX_CTRL_BYTE = 8'd7;
  localparam logic [BYTE_W-1:0] MAX_ID_BYTE   = 8'd3;

  // Data IDs
  localparam logic [ID_W-1:0] ID_PHASE_CUR = 2'd0;
  localparam logic [ID_W-1:0] ID_DC_BUS    = 2'd1;
  localparam logic [ID_W-1:0] ID_VOLTAGE   = 2'd2;
  localparam logic [ID_W-1:0] ID_SPEED     = 2'd3;

  // Drive states
  localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STATE_W-1:0] ST_FAULT   = 2'd2;

  // Drive events
  localparam logic [EVENT_W-1:0] EV_OFF   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ON    = 2'd1;
  localparam logic [EVENT_W-1:0] EV_RESET = 2'd2;

  // Command bits
  localparam int unsigned CMD_ON_BIT    = 0;
  localparam int unsigned CMD_DIR_BIT   = 1;
  localparam int unsigned CMD_RESET_BIT = 2;

  localparam logic signed [WORD_W-1:0] FRAC_NEG_ONE = 16'sh8000;
  localparam logic signed [WORD_W-1:0] FRAC_MAX     = 16'sh7fff;

  typedef struct packed {
    logic [BYTE_W-1:0]        cmd;
    logic [STAT_W-1:0]        stat;
    logic [ID_W-1:0]          id;
    logic [WORD_W-1:0]        word;
    logic [EVENT_W-1:0]       event_code;
    logic signed [WORD_W-1:0] target;
  } frame_t;

  function automatic logic signed [WORD_W-1:0] sat_neg(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v == FRAC_NEG_ONE) begin
      r = FRAC_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

>>> hdl/mcfp_front.sv
module mcfp_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mcfp_pkg::BYTE_W-1:0]          in_rx_byte,
  input  logic [mcfp_pkg::STATE_W-1:0]         in_motor_state,
  input  logic signed [mcfp_pkg::WORD_W-1:0]   in_motor_speed,
  input  logic signed [mcfp_pkg::WORD_W-1:0]   in_current_magnitude,
  input  logic signed [mcfp_pkg::WORD_W-1:0]   in_output_voltage,
  input  logic                                 q_full,
  output logic                                 q_push,
  output mcfp_pkg::frame_t                     q_frame
);

  logic [mcfp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [mcfp_pkg::BYTE_W-1:0] store_r [mcfp_pkg::STORE_DEPTH];
  logic [mcfp_pkg::WORD_W-1:0] freq_r, freq_nxt;
  logic                        accept;
  logic                        store_we;
  logic [1:0]                  store_idx;
  logic [mcfp_pkg::ID_W-1:0]   id;
  logic signed [mcfp_pkg::WORD_W-1:0] fw;
  logic [mcfp_pkg::BYTE_W-1:0] cmd;

  assign in_ready = (pos_r != mcfp_pkg::POS_DATA_H) || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (pos_r == mcfp_pkg::POS_DATA_H);

  always_comb begin
    pos_nxt   = pos_r;
    freq_nxt  = freq_r;
    store_we  = 1'b0;
    store_idx = pos_r[1:0];
    if (accept) begin
      case (pos_r)
        mcfp_pkg::POS_CMD, mcfp_pkg::POS_STATUS: begin
          if (in_rx_byte > mcfp_pkg::MAX_CTRL_BYTE) begin
            pos_nxt = mcfp_pkg::POS_CMD;
          end else begin
            store_we = 1'b1;
            pos_nxt  = pos_r + 3'd1;
          end
        end
        mcfp_pkg::POS_ID: begin
          if (in_rx_byte > mcfp_pkg::MAX_ID_BYTE) begin
            pos_nxt = mcfp_pkg::POS_CMD;
          end else begin
            store_we = 1'b1;
            pos_nxt  = mcfp_pkg::POS_DATA_L;
          end
        end
        mcfp_pkg::POS_DATA_L: begin
          store_we = 1'b1;
          pos_nxt  = mcfp_pkg::POS_DATA_H;
        end
        mcfp_pkg::POS_DATA_H: begin
          freq_nxt = in_motor_speed;
          pos_nxt  = mcfp_pkg::POS_CMD;
        end
        default: begin
          pos_nxt = mcfp_pkg::POS_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= mcfp_pkg::POS_CMD;
      freq_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      freq_r <= freq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= in_rx_byte;
    end
  end

  assign cmd = store_r[0];
  assign id  = store_r[2][mcfp_pkg::ID_W-1:0];
  assign fw  = (id == mcfp_pkg::ID_SPEED) ? {in_rx_byte, store_r[3]} : freq_r;

  always_comb begin
    q_frame.cmd  = cmd;
    q_frame.id   = id;
    q_frame.stat = {in_motor_state == mcfp_pkg::ST_FAULT,
                    (!in_motor_speed[mcfp_pkg::WORD_W-1]) && (in_motor_speed != '0),
                    in_motor_state == mcfp_pkg::ST_RUNNING};
    if (cmd[mcfp_pkg::CMD_RESET_BIT] && (in_motor_state == mcfp_pkg::ST_FAULT)) begin
      q_frame.event_code = mcfp_pkg::EV_RESET;
    end else if (cmd[mcfp_pkg::CMD_ON_BIT]) begin
      q_frame.event_code = mcfp_pkg::EV_ON;
    end else begin
      q_frame.event_code = mcfp_pkg::EV_OFF;
    end
    q_frame.target = cmd[mcfp_pkg::CMD_DIR_BIT] ? fw : mcfp_pkg::sat_neg(fw);
    case (id)
      mcfp_pkg::ID_PHASE_CUR: q_frame.word = in_current_magnitude;
      mcfp_pkg::ID_DC_BUS:    q_frame.word = '0;
      mcfp_pkg::ID_VOLTAGE:   q_frame.word = in_output_voltage;
      default:                q_frame.word = in_motor_speed;
    endcase
  end

endmodule

>>> hdl/mcfp_queue.sv
module mcfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcfp_pkg::frame_t  push_frame,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output mcfp_pkg::frame_t  head_frame
);

  mcfp_pkg::frame_t                entry_r [mcfp_pkg::QUEUE_DEPTH];
  logic [mcfp_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mcfp_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mcfp_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full       = (cnt_r == mcfp_pkg::QCNT_W'(mcfp_pkg::QUEUE_DEPTH));
  assign not_empty  = (cnt_r != '0);
  assign head_frame = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mcfp_pkg::QPTR_W'(mcfp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + mcfp_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcfp_pkg::QPTR_W'(mcfp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + mcfp_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + mcfp_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - mcfp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

>>> hdl/mcfp_back.sv
module mcfp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  mcfp_pkg::frame_t                    q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcfp_pkg::BYTE_W-1:0]         out_tx_byte,
  output logic                                out_last_byte,
  output logic [mcfp_pkg::EVENT_W-1:0]        out_drive_event,
  output logic signed [mcfp_pkg::WORD_W-1:0]  out_speed_target
);

  mcfp_pkg::frame_t                   cur_r;
  logic                               active_r, active_nxt;
  logic [mcfp_pkg::POS_W-1:0]         idx_r, idx_nxt;
  logic                               valid_r, valid_nxt;
  logic [mcfp_pkg::BYTE_W-1:0]        byte_r, byte_sel;
  logic                               last_r;
  logic [mcfp_pkg::EVENT_W-1:0]       event_r;
  logic signed [mcfp_pkg::WORD_W-1:0] target_r;
  logic                               advance;
  logic                               is_last;

  assign is_last = (idx_r == mcfp_pkg::RPL_WORD_H);
  assign advance = active_r && (!valid_r || out_ready);
  assign q_pop   = q_not_empty && (!active_r || (advance && is_last));

  always_comb begin
    case (idx_r)
      mcfp_pkg::RPL_CMD:    byte_sel = cur_r.cmd;
      mcfp_pkg::RPL_STATUS: byte_sel = {{(mcfp_pkg::BYTE_W - mcfp_pkg::STAT_W){1'b0}},
                                        cur_r.stat};
      mcfp_pkg::RPL_ID:     byte_sel = {{(mcfp_pkg::BYTE_W - mcfp_pkg::ID_W){1'b0}},
                                        cur_r.id};
      mcfp_pkg::RPL_WORD_L: byte_sel = cur_r.word[mcfp_pkg::BYTE_W-1:0];
      mcfp_pkg::RPL_WORD_H: byte_sel = cur_r.word[mcfp_pkg::WORD_W-1:mcfp_pkg::BYTE_W];
      default:              byte_sel = '0;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      idx_nxt    = mcfp_pkg::RPL_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= mcfp_pkg::RPL_CMD;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (advance) begin
      byte_r   <= byte_sel;
      last_r   <= is_last;
      event_r  <= cur_r.event_code;
      target_r <= cur_r.target;
    end
  end

  assign out_valid        = valid_r;
  assign out_tx_byte      = byte_r;
  assign out_last_byte    = last_r;
  assign out_drive_event  = event_r;
  assign out_speed_target = target_r;

endmodule

>>> hdl/motor_command_frame_parser.sv
// Channel | Direction | Payload
// in_     | input     | rx_byte, motor_state, motor_speed, current_magnitude, output_voltage
// out_    | output    | tx_byte, last_byte, drive_event, speed_target
//
// Bytes one to four of a frame, and dropped bytes, are never stalled.
// A completed frame gives five reply items from the reply byte sequencer,
// back to back while out_ready is high.
// Two decoded frames queue between parser and sequencer; the fifth byte of a
// frame stalls only while that queue is full.
// Reset (synchronous, active low) clears position, frequency word, queue, valid.
module motor_command_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mcfp_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic [mcfp_pkg::STATE_W-1:0]        in_motor_state,
  input  logic signed [mcfp_pkg::WORD_W-1:0]  in_motor_speed,
  input  logic signed [mcfp_pkg::WORD_W-1:0]  in_current_magnitude,
  input  logic signed [mcfp_pkg::WORD_W-1:0]  in_output_voltage,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcfp_pkg::BYTE_W-1:0]         out_tx_byte,
  output logic                                out_last_byte,
  output logic [mcfp_pkg::EVENT_W-1:0]        out_drive_event,
  output logic signed [mcfp_pkg::WORD_W-1:0]  out_speed_target
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_not_empty;
  mcfp_pkg::frame_t push_frame;
  mcfp_pkg::frame_t head_frame;

  mcfp_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .in_motor_state       (in_motor_state),
    .in_motor_speed       (in_motor_speed),
    .in_current_magnitude (in_current_magnitude),
    .in_output_voltage    (in_output_voltage),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_frame              (push_frame)
  );

  mcfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head_frame (head_frame)
  );

  mcfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (head_frame),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_last_byte    (out_last_byte),
    .out_drive_event  (out_drive_event),
    .out_speed_target (out_speed_target)
  );

endmodule

>>> hdl/mcfp_checker.sv
`include "motor_command_frame_parser_defines.svh"

module mcfp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [mcfp_pkg::BYTE_W-1:0]         out_tx_byte,
  input logic                                out_last_byte,
  input logic [mcfp_pkg::EVENT_W-1:0]        out_drive_event,
  input logic signed [mcfp_pkg::WORD_W-1:0]  out_speed_target
);

  `MCFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tx_byte) && $stable(out_last_byte), "reply item changed while stalled")
  `MCFP_ASSERT_NEXT(a_reply_no_gap, clk, rst_n, out_valid && out_ready && !out_last_byte, out_valid, "gap inside a reply frame")
  `MCFP_ASSERT_NEXT(a_frame_fields, clk, rst_n, out_valid && out_ready && !out_last_byte, $stable(out_drive_event) && $stable(out_speed_target), "event or target changed inside a reply frame")
  `MCFP_ASSERT_NOW(a_event_code, clk, rst_n, out_valid, out_drive_event != 2'd3, "unused drive event code")

endmodule

bind motor_command_frame_parser mcfp_checker u_mcfp_checker (.*);
